### design/rau_pkg.sv
// Shared types, opcodes and constants for the rational arithmetic unit.
package rau_pkg;

	localparam int WIDTH_DEF = 32;
	localparam int FW        = 32;          // operand field width
	localparam int DW        = 2 * FW;      // exact intermediate width
	localparam int CMD_W     = 4;
	localparam int IN_BITS   = CMD_W + 5 * FW;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 64;

	localparam logic [CMD_W-1:0] CMD_ADD    = 4'd0;
	localparam logic [CMD_W-1:0] CMD_SUB    = 4'd1;
	localparam logic [CMD_W-1:0] CMD_MUL    = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DIV    = 4'd3;
	localparam logic [CMD_W-1:0] CMD_MULINT = 4'd4;
	localparam logic [CMD_W-1:0] CMD_DIVINT = 4'd5;
	localparam logic [CMD_W-1:0] CMD_INV    = 4'd6;
	localparam logic [CMD_W-1:0] CMD_ABS    = 4'd7;
	localparam logic [CMD_W-1:0] CMD_NEG    = 4'd8;

	// Numerator = p0x*p0y (+/-) p1x*p1y, denominator = dx*dy, all magnitudes.
	typedef struct packed {
		logic [FW-1:0] p0x;
		logic [FW-1:0] p0y;
		logic [FW-1:0] p1x;
		logic [FW-1:0] p1y;
		logic [FW-1:0] dx;
		logic [FW-1:0] dy;
		logic          s0;
		logic          s1;
		logic          sd;
	} rau_op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_SUM, ST_GCD, ST_DIV, ST_OUT
	} rau_state_t;

endpackage

### design/rau_front.sv
// Front end: unpacks an input transaction and turns it into a multiply plan.
module rau_front (
	input  logic [rau_pkg::IN_TDATA_W-1:0] tdata,
	output rau_pkg::rau_op_t               op
);
	import rau_pkg::*;

	logic [CMD_W-1:0] cmd;
	logic [FW-1:0] an_m, ad_m, bn_m, bd_m, sc_m, t_m;
	logic          an_n, ad_n, bn_n, bd_n, sc_n, t_n;
	logic [FW-1:0] f_an, f_ad, f_bn, f_bd, f_sc;

	assign cmd  = tdata[CMD_W-1:0];
	assign f_an = tdata[CMD_W +: FW];
	assign f_ad = tdata[CMD_W + FW +: FW];
	assign f_bn = tdata[CMD_W + 2*FW +: FW];
	assign f_bd = tdata[CMD_W + 3*FW +: FW];
	assign f_sc = tdata[CMD_W + 4*FW +: FW];

	always_comb begin
		an_n = f_an[FW-1];
		an_m = an_n ? (~f_an + 1'b1) : f_an;
		ad_n = f_ad[FW-1];
		ad_m = ad_n ? (~f_ad + 1'b1) : f_ad;
		if (ad_m == '0) begin
			ad_m = FW'(1);
			ad_n = 1'b0;
		end
		bn_n = f_bn[FW-1];
		bn_m = bn_n ? (~f_bn + 1'b1) : f_bn;
		bd_n = f_bd[FW-1];
		bd_m = bd_n ? (~f_bd + 1'b1) : f_bd;
		if (bd_m == '0) begin
			bd_m = FW'(1);
			bd_n = 1'b0;
		end
		sc_n = f_sc[FW-1];
		sc_m = sc_n ? (~f_sc + 1'b1) : f_sc;
		t_m  = bn_m;
		t_n  = bn_n;
		if (t_m == '0) begin
			t_m = FW'(1);
			t_n = 1'b0;
		end
	end

	// Single-term results leave the second product at zero with a matching sign.
	always_comb begin
		op.p1x = '0;
		op.p1y = FW'(1);
		op.p0y = FW'(1);
		op.dy  = FW'(1);
		op.p0x = an_m;
		op.dx  = ad_m;
		op.s0  = an_n;
		op.sd  = ad_n;
		unique case (cmd)
			CMD_ADD, CMD_SUB: begin
				op.p0y = bd_m;
				op.s0  = an_n ^ bd_n;
				op.p1x = bn_m;
				op.p1y = ad_m;
				op.dy  = bd_m;
				op.sd  = ad_n ^ bd_n;
			end
			CMD_MUL: begin
				op.p0y = bn_m;
				op.s0  = an_n ^ bn_n;
				op.dy  = bd_m;
				op.sd  = ad_n ^ bd_n;
			end
			CMD_DIV: begin
				op.p0y = bd_m;
				op.s0  = an_n ^ bd_n;
				op.dy  = t_m;
				op.sd  = ad_n ^ t_n;
			end
			CMD_MULINT: begin
				op.p0y = sc_m;
				op.s0  = an_n ^ sc_n;
			end
			CMD_DIVINT: begin
				op.dy = sc_m;
				op.sd = ad_n ^ sc_n;
			end
			CMD_INV: begin
				op.p0x = ad_m;
				op.s0  = ad_n;
				op.dx  = an_m;
				op.sd  = an_n;
			end
			CMD_ABS: begin
				op.s0 = 1'b0;
				op.sd = 1'b0;
			end
			CMD_NEG: begin
				op.s0 = ~an_n;
			end
			default: begin
			end
		endcase
		op.s1 = (cmd == CMD_ADD) ? (bn_n ^ ad_n) :
			(cmd == CMD_SUB) ? (~bn_n ^ ad_n) : op.s0;
	end

endmodule

### design/rau_fifo.sv
// Two-entry queue between the front end and the arithmetic sequencer.
module rau_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rau_pkg::rau_op_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output rau_pkg::rau_op_t rdata
);
	import rau_pkg::*;

	rau_op_t    mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### design/rau_back.sv
// Back end: shared multiplier, binary gcd, exact division and result register.
module rau_back #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	input  rau_pkg::rau_op_t op,
	output logic             op_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import rau_pkg::*;

	localparam int CW = $clog2(DW);
	localparam int KW = $clog2(DW) + 1;

	rau_state_t     state_q, state_d;
	rau_op_t        op_q;
	logic [DW-1:0]  prod_q, t0_q, t1_q;
	logic [DW-1:0]  ga_q, gb_q, nq_q, dq_q, nr_q, dr_q, dv_q;
	logic [KW-1:0]  k_q;
	logic [CW-1:0]  cnt_q;
	logic           sn_q, sd_q;
	logic           out_free, gcd_done, div_done, load_out;
	logic [FW-1:0]  mul_a, mul_b;
	logic [DW-1:0]  sum_m, den_m, g_odd;
	logic           sum_n;
	logic [DW:0]    nrem, drem;
	logic           nbit, dbit;
	logic [DW-1:0]  half, tc;
	logic           neg, ovf;
	logic [31:0]    res_num;
	logic [30:0]    res_den;

	assign out_free = !m_tvalid || m_tready;
	assign gcd_done = (ga_q == '0) || (gb_q == '0);
	assign div_done = (cnt_q == CW'(DW - 1));
	assign g_odd    = ga_q | gb_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (op_valid) state_d = ST_MUL0;
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_SUM;
			ST_SUM:  state_d = ST_GCD;
			ST_GCD:  if (gcd_done) state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op_pop   = 1'b0;
		load_out = 1'b0;
		mul_a    = op_q.p0x;
		mul_b    = op_q.p0y;
		unique case (state_q)
			ST_IDLE: op_pop = op_valid;
			ST_MUL1: begin
				mul_a = op_q.p1x;
				mul_b = op_q.p1y;
			end
			ST_MUL2: begin
				mul_a = op_q.dx;
				mul_b = op_q.dy;
			end
			ST_OUT:  load_out = out_free;
			default: begin
			end
		endcase
	end

	// Signed-magnitude sum of the two numerator products.
	always_comb begin
		if (op_q.s0 == op_q.s1) begin
			sum_m = t0_q + t1_q;
			sum_n = op_q.s0;
		end else if (t0_q >= t1_q) begin
			sum_m = t0_q - t1_q;
			sum_n = op_q.s0;
		end else begin
			sum_m = t1_q - t0_q;
			sum_n = op_q.s1;
		end
		den_m = (prod_q == '0) ? DW'(1) : prod_q;
	end

	always_comb begin
		nrem = {nr_q, nq_q[DW-1]};
		nbit = (nrem >= {1'b0, dv_q});
		if (nbit) nrem = nrem - {1'b0, dv_q};
		drem = {dr_q, dq_q[DW-1]};
		dbit = (drem >= {1'b0, dv_q});
		if (dbit) drem = drem - {1'b0, dv_q};
	end

	// Final sign, overflow check and truncation to the configured width.
	always_comb begin
		half = DW'(1) << (WIDTH - 1);
		neg  = (sn_q != sd_q) && (nq_q != '0);
		ovf  = neg ? (nq_q > half) : (nq_q > half - 1'b1);
		if (dq_q > half - 1'b1) ovf = 1'b1;
		tc = neg ? (~nq_q + 1'b1) : nq_q;
		for (int i = 0; i < 32; i++) begin
			res_num[i] = (i < WIDTH) ? tc[i] : tc[WIDTH-1];
		end
		for (int i = 0; i < 31; i++) begin
			res_den[i] = (i < WIDTH) ? dq_q[i] : 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= DW'(mul_a) * DW'(mul_b);
		unique case (state_q)
			ST_IDLE: op_q <= op;
			ST_MUL1: t0_q <= prod_q;
			ST_MUL2: t1_q <= prod_q;
			ST_SUM: begin
				nq_q <= sum_m;
				dq_q <= den_m;
				ga_q <= sum_m;
				gb_q <= den_m;
				sn_q <= sum_n;
				sd_q <= (prod_q == '0) ? 1'b0 : op_q.sd;
				k_q  <= '0;
			end
			ST_GCD: begin
				if (gcd_done) begin
					// The gcd is g_odd shifted by k; drop the power of two first.
					nq_q  <= nq_q >> k_q;
					dq_q  <= dq_q >> k_q;
					dv_q  <= g_odd;
					nr_q  <= '0;
					dr_q  <= '0;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					k_q  <= k_q + 1'b1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= (ga_q - gb_q) >> 1;
				end else begin
					gb_q <= (gb_q - ga_q) >> 1;
				end
			end
			ST_DIV: begin
				nr_q <= nrem[DW-1:0];
				dr_q <= drem[DW-1:0];
				nq_q <= {nq_q[DW-2:0], nbit};
				dq_q <= {dq_q[DW-2:0], dbit};
			end
			default: begin
			end
		endcase
		if (load_out) begin
			m_tdata <= {ovf, res_den, res_num};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

### design/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: front end, queue and sequencer.
// Each item passes through the multiply states, the sum, the gcd loop (one
// binary gcd step per cycle over 64-bit magnitudes), exact division and output.
// The sequencer handles one item at a time, while the two-entry queue and the
// result register keep both sides moving.
// Reset: arst_n clears the queue, the sequencer state and the result valid.
module rational_arithmetic_unit #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// cmd[3:0], a_num[35:4], a_den[67:36], b_num[99:68], b_den[131:100],
	// scalar[163:132], zero fill above
	input  logic [rau_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// res_num[31:0], res_den[62:32], overflow[63]
	output logic [rau_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import rau_pkg::*;

	rau_op_t op_in, op_head;
	logic    q_full, q_valid, q_pop;

	assign s_tready = !q_full;

	rau_front u_front (
		.tdata (s_tdata),
		.op    (op_in)
	);

	rau_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (s_tvalid && s_tready),
		.wdata  (op_in),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (op_head)
	);

	rau_back #(.WIDTH(WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_valid),
		.op       (op_head),
		.op_pop   (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// A reduced denominator is at least one, so a zero field means it was cut.
	a_den_cut_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		(WIDTH <= 32) && m_tvalid && (m_tdata[62:32] == 31'd0) |-> m_tdata[63])
		else $error("zero denominator field without overflow");

	// A zero result is always reduced to 0/1.
	a_zero_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		(WIDTH <= 32) && m_tvalid && (m_tdata[31:0] == 32'd0) && !m_tdata[63]
		|-> (m_tdata[62:32] == 31'd1))
		else $error("zero numerator not reduced to 0/1");

	// The queue is never popped while empty.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule

### sim/tb.sv
// Self-checking testbench for the rational arithmetic unit with a built-in fraction predictor.
module tb;
	import rau_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RED = 4'd9;
	localparam int WATCH_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	typedef struct packed {
		logic [31:0] num;
		logic [30:0] den;
		logic        ovf;
	} frac_res_t;

	// Sign-magnitude helpers for the exact double-width arithmetic.
	typedef struct packed {
		logic [63:0] m;
		logic        n;
	} smag_t;

	function automatic smag_t to_smag(logic [31:0] v);
		smag_t s;
		s.n = v[31];
		s.m = v[31] ? 64'(-v) & 64'hFFFF_FFFF : 64'(v);
		if (v == 32'h8000_0000) s.m = 64'h8000_0000;
		return s;
	endfunction

	function automatic smag_t den_fix(smag_t d);
		if (d.m == 0) begin
			d.m = 1;
			d.n = 1'b0;
		end
		return d;
	endfunction

	function automatic smag_t smul(smag_t a, smag_t b);
		smag_t r;
		r.m = a.m * b.m;
		r.n = a.n ^ b.n;
		return r;
	endfunction

	function automatic smag_t sadd(smag_t a, smag_t b);
		smag_t r;
		if (a.n == b.n) begin
			r.m = a.m + b.m;
			r.n = a.n;
		end else if (a.m >= b.m) begin
			r.m = a.m - b.m;
			r.n = a.n;
		end else begin
			r.m = b.m - a.m;
			r.n = b.n;
		end
		return r;
	endfunction

	function automatic frac_res_t predict_fraction(logic [CMD_W-1:0] cmd, logic [31:0] an_r,
			logic [31:0] ad_r, logic [31:0] bn_r, logic [31:0] bd_r, logic [31:0] sc_r);
		smag_t an, ad, bn, bd, sc, num, den;
		logic [63:0] x, y, r, nm, dm, tc;
		logic [63:0] half;
		logic neg, ovf;
		frac_res_t res;
		an = to_smag(an_r);
		ad = den_fix(to_smag(ad_r));
		bn = to_smag(bn_r);
		bd = den_fix(to_smag(bd_r));
		sc = to_smag(sc_r);
		case (cmd)
			CMD_ADD, CMD_SUB: begin
				if (cmd == CMD_SUB) bn.n = ~bn.n;
				num = sadd(smul(an, bd), smul(bn, ad));
				den = smul(ad, bd);
			end
			CMD_MUL: begin
				num = smul(an, bn);
				den = smul(ad, bd);
			end
			CMD_DIV: begin
				num = smul(an, bd);
				den = smul(ad, den_fix(bn));
			end
			CMD_MULINT: begin
				num = smul(an, sc);
				den = ad;
			end
			CMD_DIVINT: begin
				num = an;
				den = smul(ad, sc);
			end
			CMD_INV: begin
				num = ad;
				den = an;
			end
			CMD_ABS: begin
				num = an;
				num.n = 1'b0;
				den = ad;
				den.n = 1'b0;
			end
			CMD_NEG: begin
				num = an;
				num.n = ~an.n;
				den = ad;
			end
			default: begin
				num = an;
				den = ad;
			end
		endcase
		den = den_fix(den);
		x = num.m;
		y = den.m;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		nm = num.m / x;
		dm = den.m / x;
		neg = (num.n != den.n) && nm != 0;
		half = 64'h8000_0000;
		ovf = neg ? (nm > half) : (nm > half - 1);
		if (dm > half - 1) ovf = 1'b1;
		tc = neg ? -nm : nm;
		res.num = tc[31:0];
		res.den = dm[30:0];
		res.ovf = ovf;
		return res;
	endfunction

	class fraction_scoreboard;
		frac_res_t pending[$];
		int errors;
		int checked;

		function void note_item(logic [IN_TDATA_W-1:0] d);
			pending.push_back(predict_fraction(d[3:0], d[35:4], d[67:36], d[99:68],
				d[131:100], d[163:132]));
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] d);
			frac_res_t want;
			if (pending.size() == 0) begin
				$error("result 0x%h arrived with nothing expected", d);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (d[31:0] !== want.num) begin
				$error("res_num expected %0d got %0d", $signed(want.num), $signed(d[31:0]));
				errors++;
			end
			if (d[62:32] !== want.den) begin
				$error("res_den expected %0d got %0d", want.den, d[62:32]);
				errors++;
			end
			if (d[63] !== want.ovf) begin
				$error("overflow expected %0b got %0b", want.ovf, d[63]);
				errors++;
			end
		endfunction
	endclass

	fraction_scoreboard fsb;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_recv;
	int idle_cycles;
	int sent;

	rational_arithmetic_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Output side: sample at the rising edge, change tready at the falling edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) fsb.check_result(m_tdata);
		if (arst_n && ((m_tvalid && m_tready) || (s_tvalid && s_tready)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(negedge clk) begin
		if (!arst_n || hold_recv)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			4: return 32'(int'($urandom_range(40)) - 20);
			5: return $urandom;
			6: return 32'(int'($urandom_range(2000)) - 1000);
			default: return 32'(int'($urandom_range(200000)) - 100000);
		endcase
	endfunction

	// Offers one item and holds it until the block takes it; tvalid stays up afterwards.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd, logic [31:0] sc);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'({sc, bd, bn, ad, an, cmd});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		fsb.note_item(IN_TDATA_W'({sc, bd, bn, ad, an, cmd}));
		sent++;
		@(negedge clk);
	endtask

	// Ends a burst of items by dropping tvalid.
	task automatic stop_input();
		s_tvalid <= 1'b0;
	endtask

	task automatic send_random(int n);
		repeat (n) send_item(4'($urandom_range(15)), pick_value(), pick_value(),
			pick_value(), pick_value(), pick_value());
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (fsb.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		fsb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		hold_recv = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		idle_cycles = 0;
		sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: every opcode, zero terms, extreme values and wrap cases.
		send_item(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 32'd0);
		send_item(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 32'd0);
		send_item(CMD_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 32'd0);
		send_item(CMD_DIV, 32'd3, 32'd4, 32'd0, 32'd5, 32'd0);
		send_item(CMD_DIV, 32'd3, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
		send_item(CMD_MULINT, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0, 32'h7FFF_FFFF);
		send_item(CMD_DIVINT, 32'd6, 32'd4, 32'd0, 32'd0, 32'd0);
		send_item(CMD_DIVINT, 32'd6, 32'h8000_0000, 32'd0, 32'd0, 32'hFFFF_FFFE);
		send_item(CMD_INV, 32'd0, 32'd7, 32'd0, 32'd0, 32'd0);
		send_item(CMD_INV, 32'hFFFF_FFFC, 32'd6, 32'd0, 32'd0, 32'd0);
		send_item(CMD_ABS, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
		send_item(CMD_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd0, 32'd0);
		send_item(CMD_NEG, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
		send_item(CMD_RED, 32'd0, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
		send_item(CMD_RED, 32'd12, 32'hFFFF_FFF8, 32'd0, 32'd0, 32'd0);
		send_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		send_item(4'd10, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000);
		send_item(CMD_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'd0);
		send_item(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'd0);
		stop_input();
		wait_drained();

		// Receiver held off while the sender keeps offering, so the input stalls.
		hold_recv = 1'b1;
		fork
			begin
				repeat (1500) @(negedge clk);
				hold_recv = 1'b0;
			end
			begin
				send_random(8);
				stop_input();
			end
		join
		wait_drained();

		send_idle_pct = 28;
		recv_idle_pct = 48;
		send_random(280);
		stop_input();
		wait_drained();
		send_idle_pct = 48;
		recv_idle_pct = 28;
		send_random(280);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(260);
		stop_input();
		wait_drained();
		repeat (250) @(negedge clk);

		$display("Sent %0d items over all ten opcodes, unused codes and extreme operands;",
			sent);
		$display("checked %0d results under random stalls on both sides.", fsb.checked);
		if (fsb.errors == 0 && fsb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
